// ===== sv/drox_pkg.sv =====
`timescale 1ns / 1ps

package drox_pkg;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LEN,
    PH_VALUE
  } phase_t;

  localparam int unsigned NSLOT = 7;

  typedef logic [2:0] slot_t;

  localparam slot_t SLOT_MASK   = 3'd0;
  localparam slot_t SLOT_ROUTER = 3'd1;
  localparam slot_t SLOT_DNS    = 3'd2;
  localparam slot_t SLOT_LEASE  = 3'd3;
  localparam slot_t SLOT_SERVER = 3'd4;
  localparam slot_t SLOT_RENEW  = 3'd5;
  localparam slot_t SLOT_REBIND = 3'd6;
  localparam slot_t SLOT_NONE   = 3'd7;

  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_MASK    = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_LEASE   = 8'd51;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER  = 8'd54;
  localparam logic [7:0] OPT_RENEW   = 8'd58;
  localparam logic [7:0] OPT_REBIND  = 8'd59;
  localparam logic [7:0] OPT_END     = 8'd255;

  localparam logic [7:0] OP_REPLY = 8'd2;

  localparam logic [7:0] IDX_OP         = 8'd0;
  localparam logic [7:0] IDX_XID_LO     = 8'd4;
  localparam logic [7:0] IDX_XID_HI     = 8'd7;
  localparam logic [7:0] IDX_YIADDR_LO  = 8'd16;
  localparam logic [7:0] IDX_YIADDR_HI  = 8'd19;
  localparam logic [7:0] IDX_COOKIE_LO  = 8'd236;
  localparam logic [7:0] IDX_COOKIE_HI  = 8'd239;
  localparam logic [7:0] IDX_OPTIONS    = 8'd240;
  localparam logic [7:0] IDX_MSGTYPE    = 8'd242;
  localparam logic [7:0] IDX_MIN_REPLY  = 8'd241;
  localparam logic [7:0] IDX_MAX        = 8'd255;

  localparam logic [3:0][7:0] COOKIE = {8'h63, 8'h82, 8'h53, 8'h63};

  typedef struct packed {
    logic [NSLOT-1:0][31:0] cap;
    logic [NSLOT-1:0]       found;
    logic [5:0]             dns;
  } walk_t;

  function automatic slot_t slot_of(input logic [7:0] code);
    slot_t s;
    unique case (code)
      OPT_MASK:   s = SLOT_MASK;
      OPT_ROUTER: s = SLOT_ROUTER;
      OPT_DNS:    s = SLOT_DNS;
      OPT_LEASE:  s = SLOT_LEASE;
      OPT_SERVER: s = SLOT_SERVER;
      OPT_RENEW:  s = SLOT_RENEW;
      OPT_REBIND: s = SLOT_REBIND;
      default:    s = SLOT_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/drox_in_if.sv =====
`timescale 1ns / 1ps

interface drox_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/drox_out_if.sv =====
`timescale 1ns / 1ps

interface drox_out_if ();
  logic        valid;
  logic        ready;
  logic        is_reply;
  logic [7:0]  msg_type;
  logic [31:0] offered_addr;
  logic [31:0] subnet_mask;
  logic [31:0] router_addr;
  logic [31:0] server_id;
  logic [31:0] lease_secs;
  logic [31:0] renew_secs;
  logic [31:0] rebind_secs;
  logic [31:0] dns_first;
  logic [5:0]  dns_count;
  logic [6:0]  found_flags;

  modport source (
    output valid, input ready,
    output is_reply, output msg_type, output offered_addr, output subnet_mask,
    output router_addr, output server_id, output lease_secs, output renew_secs,
    output rebind_secs, output dns_first, output dns_count, output found_flags
  );
  modport sink (
    input valid, output ready,
    input is_reply, input msg_type, input offered_addr, input subnet_mask,
    input router_addr, input server_id, input lease_secs, input renew_secs,
    input rebind_secs, input dns_first, input dns_count, input found_flags
  );
endinterface

// ===== sv/drox_opt_walk.sv =====
`timescale 1ns / 1ps

module drox_opt_walk import drox_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       clear,
  input  logic [7:0] data_byte,
  output walk_t      walk_nxt
);

  phase_t                 phase_r, phase_nxt;
  slot_t                  slot_r, slot_nxt;
  logic [7:0]             left_r, left_nxt;
  logic [2:0]             shift_r, shift_nxt;
  logic                   ended_r, ended_nxt;
  logic [NSLOT-1:0][31:0] cap_r, cap_nxt;
  logic [NSLOT-1:0]       found_r, found_nxt;
  logic [5:0]             dns_r, dns_nxt;
  logic                   walk_en;
  slot_t                  code_slot;

  assign walk_en   = step && !ended_r;
  assign code_slot = slot_of(data_byte);

  always_comb begin
    phase_nxt = phase_r;
    if (walk_en) begin
      unique case (phase_r)
        PH_LEN: begin
          phase_nxt = (data_byte != 8'd0) ? PH_VALUE : PH_CODE;
        end
        PH_VALUE: begin
          if (left_r <= 8'd1) begin
            phase_nxt = PH_CODE;
          end
        end
        default: begin
          if (data_byte != OPT_END && data_byte != OPT_PAD) begin
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
  end

  always_comb begin
    slot_nxt  = slot_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    ended_nxt = ended_r;
    cap_nxt   = cap_r;
    found_nxt = found_r;
    dns_nxt   = dns_r;
    if (walk_en) begin
      unique case (phase_r)
        PH_LEN: begin
          left_nxt  = data_byte;
          shift_nxt = 3'd0;
          if (slot_r == SLOT_DNS) begin
            dns_nxt = data_byte[7:2];
          end
        end
        PH_VALUE: begin
          if (slot_r != SLOT_NONE && !shift_r[2]) begin
            cap_nxt[slot_r][{~shift_r[1:0], 3'b000} +: 8] = data_byte;
            shift_nxt = shift_r + 3'd1;
          end
          if (left_r != 8'd0) begin
            left_nxt = left_r - 8'd1;
          end
        end
        default: begin
          if (data_byte == OPT_END) begin
            ended_nxt = 1'b1;
          end else if (data_byte != OPT_PAD) begin
            if (code_slot != SLOT_NONE && !found_r[code_slot]) begin
              found_nxt[code_slot] = 1'b1;
              cap_nxt[code_slot]   = 32'd0;
              slot_nxt             = code_slot;
            end else begin
              slot_nxt = SLOT_NONE;
            end
          end
        end
      endcase
    end
  end

  assign walk_nxt.cap   = cap_nxt;
  assign walk_nxt.found = found_nxt;
  assign walk_nxt.dns   = dns_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_CODE;
      slot_r  <= SLOT_NONE;
      left_r  <= 8'd0;
      shift_r <= 3'd0;
      ended_r <= 1'b0;
      cap_r   <= '0;
      found_r <= '0;
      dns_r   <= 6'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      left_r  <= left_nxt;
      shift_r <= shift_nxt;
      ended_r <= ended_nxt;
      cap_r   <= cap_nxt;
      found_r <= found_nxt;
      dns_r   <= dns_nxt;
    end
  end

endmodule

// ===== sv/dhcp_reply_option_extractor.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake        | word
// in_ch   | in  | valid / ready    | data_byte, last_byte
// out_ch  | out | valid / ready    | is_reply .. found_flags (one per message)
// cfg     | in  | cfg_we           | cfg_wdata -> expected_xid
// One byte per cycle; every byte is parsed in the cycle it is accepted.
// The result of a message is registered on its last byte and shows the next cycle.
// A held result stalls only a new last byte; other bytes keep flowing.
// rst_n is synchronous: parser state, xid register and result valid clear.

module dhcp_reply_option_extractor import drox_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  drox_in_if.sink       in_ch,
  drox_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  logic [31:0] xid_r;
  logic [7:0]  idx_r, idx_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [7:0]  msg_type_r, msg_type_nxt;
  logic [31:0] offered_r, offered_nxt;
  logic        accept, done, step;
  logic [7:0]  xid_byte;
  walk_t       walk_nxt;
  logic        reply;

  logic        out_valid_r;
  logic        is_reply_r;
  logic [7:0]  out_msg_type_r;
  logic [31:0] out_offered_r;
  walk_t       out_walk_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready || !in_ch.last_byte;
  assign accept      = in_ch.valid && in_ch.ready;
  assign done        = accept && in_ch.last_byte;
  assign step        = accept && (idx_r >= IDX_OPTIONS);
  assign xid_byte    = xid_r[{~idx_r[1:0], 3'b000} +: 8];

  always_comb begin
    hdr_ok_nxt   = hdr_ok_r;
    msg_type_nxt = msg_type_r;
    offered_nxt  = offered_r;
    if (idx_r == IDX_OP && in_ch.data_byte != OP_REPLY) begin
      hdr_ok_nxt = 1'b0;
    end
    if (idx_r >= IDX_XID_LO && idx_r <= IDX_XID_HI && xid_byte != in_ch.data_byte) begin
      hdr_ok_nxt = 1'b0;
    end
    if (idx_r >= IDX_YIADDR_LO && idx_r <= IDX_YIADDR_HI) begin
      offered_nxt[{~idx_r[1:0], 3'b000} +: 8] = in_ch.data_byte;
    end
    if (idx_r >= IDX_COOKIE_LO && idx_r <= IDX_COOKIE_HI &&
        COOKIE[~idx_r[1:0]] != in_ch.data_byte) begin
      hdr_ok_nxt = 1'b0;
    end
    if (idx_r == IDX_OPTIONS && in_ch.data_byte != OPT_MSGTYPE) begin
      hdr_ok_nxt = 1'b0;
    end
    if (idx_r == IDX_MSGTYPE) begin
      msg_type_nxt = in_ch.data_byte;
    end
    idx_nxt = (idx_r != IDX_MAX) ? idx_r + 8'd1 : idx_r;
  end

  assign reply = hdr_ok_nxt && (idx_nxt >= IDX_MIN_REPLY);

  drox_opt_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .clear     (done),
    .data_byte (in_ch.data_byte),
    .walk_nxt  (walk_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r <= 32'd0;
    end else if (cfg_we) begin
      xid_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || done) begin
      idx_r      <= 8'd0;
      hdr_ok_r   <= 1'b1;
      msg_type_r <= 8'd0;
      offered_r  <= 32'd0;
    end else if (accept) begin
      idx_r      <= idx_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      msg_type_r <= msg_type_nxt;
      offered_r  <= offered_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      is_reply_r     <= reply;
      out_msg_type_r <= reply ? msg_type_nxt : 8'd0;
      out_offered_r  <= offered_nxt;
      out_walk_r     <= walk_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_reply     = is_reply_r;
  assign out_ch.msg_type     = out_msg_type_r;
  assign out_ch.offered_addr = out_offered_r;
  assign out_ch.subnet_mask  = out_walk_r.cap[SLOT_MASK];
  assign out_ch.router_addr  = out_walk_r.cap[SLOT_ROUTER];
  assign out_ch.server_id    = out_walk_r.cap[SLOT_SERVER];
  assign out_ch.lease_secs   = out_walk_r.cap[SLOT_LEASE];
  assign out_ch.renew_secs   = out_walk_r.cap[SLOT_RENEW];
  assign out_ch.rebind_secs  = out_walk_r.cap[SLOT_REBIND];
  assign out_ch.dns_first    = out_walk_r.cap[SLOT_DNS];
  assign out_ch.dns_count    = out_walk_r.dns;
  assign out_ch.found_flags  = out_walk_r.found;

endmodule
